[hdl/two_key_debounce_chord_detector_top_macros.svh]
// assertion macros for the two-key debounce and chord detector
// used by the top level only; no other dependencies
`ifndef TWO_KEY_DEBOUNCE_CHORD_DETECTOR_TOP_MACROS_SVH
`define TWO_KEY_DEBOUNCE_CHORD_DETECTOR_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition and consequence in the same cycle
`define TKDC_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("tkdc check failed");

// condition, consequence in the cycle after it
`define TKDC_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("tkdc check failed");

`else

`define TKDC_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define TKDC_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

[hdl/tkdc_pkg.sv]
// shared types, codes and constants for the two-key debounce and chord detector
// no dependencies
`timescale 1ns / 1ps

package tkdc_pkg;

    localparam int TimeW = 32;
    localparam int CfgW  = 16;
    localparam int CfgIndexW = 2;

    // key phase codes
    localparam logic [1:0] PhIdle       = 2'd0;
    localparam logic [1:0] PhDebouncing = 2'd1;
    localparam logic [1:0] PhConfirmed  = 2'd2;
    localparam logic [1:0] PhActive     = 2'd3;

    // event codes
    localparam logic [1:0] EvNone = 2'd0;
    localparam logic [1:0] EvKey0 = 2'd1;
    localparam logic [1:0] EvKey1 = 2'd2;
    localparam logic [1:0] EvBoth = 2'd3;

    // register indexes and reset values
    localparam logic [CfgIndexW-1:0] RegDebounceTime = 2'd0;
    localparam logic [CfgIndexW-1:0] RegChordWindow  = 2'd1;
    localparam logic [CfgW-1:0] DebounceReset = 16'd50;
    localparam logic [CfgW-1:0] ChordReset    = 16'd150;

    // status of one key after the debounce update of the current item
    typedef struct packed {
        logic [1:0]       phase;
        logic [TimeW-1:0] confirm_time;
    } key_stat_t;

    // decision of the chord resolver
    typedef struct packed {
        logic [1:0] promote;
        logic [1:0] key_event;
    } resolve_t;

endpackage

[hdl/tkdc_key.sv]
// debounce phase machine for one key
// depends on tkdc_pkg
`timescale 1ns / 1ps

module tkdc_key
    import tkdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic [TimeW-1:0] time_now,
    input  logic             level,
    input  logic             fall,
    input  logic [CfgW-1:0]  debounce_time,
    input  logic             promote,
    output key_stat_t        stat_mid,
    output logic [1:0]       phase
);

    logic [1:0]       phase_reg,        phase_next;
    logic             pending_reg,      pending_next;
    logic [TimeW-1:0] edge_time_reg,    edge_time_next;
    logic [TimeW-1:0] confirm_time_reg, confirm_time_next;
    logic [TimeW-1:0] since_edge;
    logic [1:0]       phase_mid;

    // edge flag is applied before the phase update
    always_comb
    begin
        pending_next      = pending_reg | fall;
        edge_time_next    = fall ? time_now : edge_time_reg;
        confirm_time_next = confirm_time_reg;
        phase_mid         = phase_reg;
        since_edge        = time_now - edge_time_next;
        case (phase_reg)
            PhIdle:
            begin
                if (pending_next)
                begin
                    phase_mid = PhDebouncing;
                end
            end
            PhDebouncing:
            begin
                if (since_edge >= {{(TimeW-CfgW){1'b0}}, debounce_time})
                begin
                    pending_next = 1'b0;
                    if (!level)
                    begin
                        phase_mid         = PhConfirmed;
                        confirm_time_next = time_now;
                    end
                    else
                    begin
                        phase_mid = PhIdle;
                    end
                end
            end
            default:
            begin
                // confirmed or active: release drops any stale edge
                if (level)
                begin
                    phase_mid    = PhIdle;
                    pending_next = 1'b0;
                end
            end
        endcase
        phase_next = promote ? PhActive : phase_mid;
    end

    assign stat_mid.phase        = phase_mid;
    assign stat_mid.confirm_time = confirm_time_next;
    assign phase                 = phase_reg;

    // state update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PhIdle;
            pending_reg      <= 1'b0;
            edge_time_reg    <= '0;
            confirm_time_reg <= '0;
        end
        else if (enable)
        begin
            phase_reg        <= phase_next;
            pending_reg      <= pending_next;
            edge_time_reg    <= edge_time_next;
            confirm_time_reg <= confirm_time_next;
        end
    end

endmodule

[hdl/tkdc_resolve.sv]
// chord and single-press decision from both keys' updated status
// depends on tkdc_pkg
`timescale 1ns / 1ps

module tkdc_resolve
    import tkdc_pkg::*;
(
    input  logic [TimeW-1:0] time_now,
    input  logic [CfgW-1:0]  chord_window,
    input  key_stat_t        stat0,
    input  key_stat_t        stat1,
    output resolve_t         res
);

    logic [TimeW-1:0] window_ext;
    logic [TimeW-1:0] d01, d10, age0, age1;
    logic             conf0, conf1, chord;

    assign window_ext = {{(TimeW-CfgW){1'b0}}, chord_window};
    assign d01  = stat0.confirm_time - stat1.confirm_time;
    assign d10  = stat1.confirm_time - stat0.confirm_time;
    assign age0 = time_now - stat0.confirm_time;
    assign age1 = time_now - stat1.confirm_time;
    assign conf0 = (stat0.phase == PhConfirmed);
    assign conf1 = (stat1.phase == PhConfirmed);

    // smaller wrapped distance within the window is the same as either one
    assign chord = conf0 && conf1 && ((d01 <= window_ext) || (d10 <= window_ext));

    // both-press first, then key zero, then key one
    always_comb
    begin
        res.promote   = 2'b00;
        res.key_event = EvNone;
        if (chord)
        begin
            res.promote   = 2'b11;
            res.key_event = EvBoth;
        end
        else if (conf0 && (age0 > window_ext))
        begin
            res.promote   = 2'b01;
            res.key_event = EvKey0;
        end
        else if (conf1 && (age1 > window_ext))
        begin
            res.promote   = 2'b10;
            res.key_event = EvKey1;
        end
    end

endmodule

[hdl/two_key_debounce_chord_detector_top.sv]
// top level of the two-key debounce and chord detector
// depends on tkdc_pkg, tkdc_key, tkdc_resolve and the assertion macro header
//
// Usage:
//   Input channel (in_valid / in_stall) carries one poll per item: the
//   millisecond time and level and falling-edge flags of two active-low keys.
//   Output channel (out_valid / out_stall) returns exactly one key_event per
//   poll: none, key zero, key one or both.
//   Configuration channel (cfg_valid / cfg_ready, always ready) writes
//   debounce_time (index 0) or chord_window (index 1); other indexes are
//   ignored. Write only while no poll is in flight.
//   The key state and the result register (or the skid register while a
//   result waits) are updated at the edge that accepts the poll. Throughput
//   is one poll per cycle while in_stall is low, set by the combinational
//   phase update and compare in the key and resolver logic.
//   A two-entry output buffer (result register plus skid register) lets a
//   poll be taken while a result waits; in_stall rises only once both
//   entries are full under a stalled receiver.
//   Reset puts both keys idle, clears pending edges and output buffer, and
//   loads debounce_time 50 and chord_window 150.
`timescale 1ns / 1ps

`include "two_key_debounce_chord_detector_top_macros.svh"

module two_key_debounce_chord_detector_top
    import tkdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TimeW-1:0]     time_now,
    input  logic                 level_key0,
    input  logic                 level_key1,
    input  logic                 fall_key0,
    input  logic                 fall_key1,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           key_event,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgW-1:0]      cfg_data
);

    logic [CfgW-1:0] debounce_time_reg;
    logic [CfgW-1:0] chord_window_reg;
    logic            in_acc;
    key_stat_t       stat0, stat1;
    logic [1:0]      phase0, phase1;
    resolve_t        res;

    logic       out_valid_reg,  out_valid_next;
    logic [1:0] out_event_reg,  out_event_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [1:0] skid_event_reg, skid_event_next;
    logic       out_take;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg <= DebounceReset;
            chord_window_reg  <= ChordReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                RegDebounceTime: debounce_time_reg <= cfg_data;
                RegChordWindow:  chord_window_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // handshake
    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    // per-key debounce
    tkdc_key u_key0 (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (in_acc),
        .time_now      (time_now),
        .level         (level_key0),
        .fall          (fall_key0),
        .debounce_time (debounce_time_reg),
        .promote       (res.promote[0]),
        .stat_mid      (stat0),
        .phase         (phase0)
    );

    tkdc_key u_key1 (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (in_acc),
        .time_now      (time_now),
        .level         (level_key1),
        .fall          (fall_key1),
        .debounce_time (debounce_time_reg),
        .promote       (res.promote[1]),
        .stat_mid      (stat1),
        .phase         (phase1)
    );

    // chord decision
    tkdc_resolve u_resolve (
        .time_now     (time_now),
        .chord_window (chord_window_reg),
        .stat0        (stat0),
        .stat1        (stat1),
        .res          (res)
    );

    // result register and skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_event_next  = out_event_reg;
        skid_valid_next = skid_valid_reg;
        skid_event_next = skid_event_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_event_next  = skid_event_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_acc;
                out_event_next = res.key_event;
            end
        end
        else if (in_acc)
        begin
            skid_valid_next = 1'b1;
            skid_event_next = res.key_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_event_reg  <= out_event_next;
        skid_event_reg <= skid_event_next;
    end

    assign out_valid = out_valid_reg;
    assign key_event = out_event_reg;

    // checks
    `TKDC_ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `TKDC_ASSERT_NEXT(a_both_active, clk, rst_n, in_acc && (res.key_event == EvBoth), (phase0 == PhActive) && (phase1 == PhActive))
    `TKDC_ASSERT_NEXT(a_key0_active, clk, rst_n, in_acc && (res.key_event == EvKey0), phase0 == PhActive)
    `TKDC_ASSERT_NEXT(a_key1_active, clk, rst_n, in_acc && (res.key_event == EvKey1), phase1 == PhActive)

endmodule

[tb/tb_two_key_debounce_chord_detector_top.sv]
// self-checking testbench for the two-key debounce and chord detector
// depends on tkdc_pkg and two_key_debounce_chord_detector_top; drives polls, random stalls
// and register writes; checks every key_event against a key tracker or a typed-in value
`timescale 1ns / 1ps

module tb_two_key_debounce_chord_detector_top;
    import tkdc_pkg::*;

    localparam int CycleLimit = 500000;
    localparam int PhaseCount = 7;
    localparam int PollsPerPhase = 200;
    localparam int BurstPolls = 16;
    localparam logic [CfgIndexW-1:0] RegSpareLo = 2'd2;
    localparam logic [CfgIndexW-1:0] RegSpareHi = 2'd3;

    // one poll as offered to the block, with an optional typed-in expectation
    typedef struct packed {
        logic [TimeW-1:0] now;
        logic             lvl0;
        logic             lvl1;
        logic             fall0;
        logic             fall1;
        logic             fixed_exp;
        logic [1:0]       exp_event;
    } poll_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [TimeW-1:0]     time_now;
    logic                 level_key0;
    logic                 level_key1;
    logic                 fall_key0;
    logic                 fall_key1;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           key_event;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index;
    logic [CfgW-1:0]      cfg_data;

    // typed-in expectation travelling with the current poll
    logic                 cur_fixed;
    logic [1:0]           cur_event;

    // key tracker state and its copy of the registers
    logic [1:0]       trk_phase  [2];
    logic             trk_pend   [2];
    logic [TimeW-1:0] trk_edge_t [2];
    logic [TimeW-1:0] trk_conf_t [2];
    logic [CfgW-1:0]  trk_debounce;
    logic [CfgW-1:0]  trk_window;

    logic [1:0] awaited_events [$];
    poll_t      directed_polls [$];
    int         mismatch_count;
    int         squeeze_ask;
    int         tx_calm;
    logic [TimeW-1:0] ms_now;
    bit         key_held [2];

    two_key_debounce_chord_detector_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .time_now   (time_now),
        .level_key0 (level_key0),
        .level_key1 (level_key1),
        .fall_key0  (fall_key0),
        .fall_key1  (fall_key1),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_event  (key_event),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // debounce and phase update of one key
    function automatic void track_key(int k, logic [TimeW-1:0] now, logic level, logic fall);
        if (fall)
        begin
            trk_pend[k]   = 1'b1;
            trk_edge_t[k] = now;
        end
        case (trk_phase[k])
            PhIdle:
            begin
                if (trk_pend[k])
                    trk_phase[k] = PhDebouncing;
            end
            PhDebouncing:
            begin
                if (now - trk_edge_t[k] >= {16'd0, trk_debounce})
                begin
                    trk_pend[k] = 1'b0;
                    if (!level)
                    begin
                        trk_phase[k]  = PhConfirmed;
                        trk_conf_t[k] = now;
                    end
                    else
                        trk_phase[k] = PhIdle;
                end
            end
            default:
            begin
                if (level)
                begin
                    trk_phase[k] = PhIdle;
                    trk_pend[k]  = 1'b0;
                end
            end
        endcase
    endfunction

    // event for one poll: chord first, then single keys, key zero first
    function automatic logic [1:0] predict_key_event(poll_t p);
        logic [TimeW-1:0] d_a;
        logic [TimeW-1:0] d_b;
        logic [TimeW-1:0] near_gap;
        int k;
        track_key(0, p.now, p.lvl0, p.fall0);
        track_key(1, p.now, p.lvl1, p.fall1);
        if (trk_phase[0] == PhConfirmed && trk_phase[1] == PhConfirmed)
        begin
            d_a      = trk_conf_t[0] - trk_conf_t[1];
            d_b      = trk_conf_t[1] - trk_conf_t[0];
            near_gap = (d_a < d_b) ? d_a : d_b;
            if (near_gap <= {16'd0, trk_window})
            begin
                trk_phase[0] = PhActive;
                trk_phase[1] = PhActive;
                return EvBoth;
            end
        end
        for (k = 0; k < 2; k++)
        begin
            if (trk_phase[k] == PhConfirmed && p.now - trk_conf_t[k] > {16'd0, trk_window})
            begin
                trk_phase[k] = PhActive;
                return (k == 0) ? EvKey0 : EvKey1;
            end
        end
        return EvNone;
    endfunction

    // sender gap: mostly none, some short, a few long, with calm stretches
    function automatic int pick_gap();
        int r;
        if (tx_calm > 0)
        begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            tx_calm = $urandom_range(20, 60);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random poll: presses and releases with chords, plus bounces and glitches
    function automatic poll_t random_poll(int unsigned span);
        poll_t p;
        int r;
        int k;
        logic [1:0] fall;
        logic [1:0] lvl;
        r = $urandom_range(0, 99);
        if (r < 70)
            ms_now = ms_now + $urandom_range(0, span / 8 + 2);
        else if (r < 95)
            ms_now = ms_now + $urandom_range(0, 2 * span);
        else if (r < 98)
            ms_now = $urandom;
        else
            ms_now = ms_now - $urandom_range(1, span);
        fall = 2'b00;
        for (k = 0; k < 2; k++)
        begin
            if (key_held[k])
            begin
                if ($urandom_range(0, 9) == 0)
                    key_held[k] = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                key_held[k] = 1'b1;
                fall[k] = 1'b1;
            end
        end
        // a press often brings the other key down with it
        if (fall[0] && !key_held[1] && $urandom_range(0, 1) == 1)
        begin
            key_held[1] = 1'b1;
            fall[1] = 1'b1;
        end
        lvl = {~key_held[1], ~key_held[0]};
        if ($urandom_range(0, 19) == 0)
            fall[$urandom_range(0, 1)] = 1'b1;
        if ($urandom_range(0, 29) == 0)
            lvl[$urandom_range(0, 1)] ^= 1'b1;
        p = '{now: ms_now, lvl0: lvl[0], lvl1: lvl[1], fall0: fall[0], fall1: fall[1],
              fixed_exp: 1'b0, exp_event: EvNone};
        return p;
    endfunction

    task automatic add_poll(logic [TimeW-1:0] now, logic l0, logic l1, logic f0, logic f1,
                            logic fixed, logic [1:0] ev);
        directed_polls.push_back('{now: now, lvl0: l0, lvl1: l1, fall0: f0, fall1: f1,
                                   fixed_exp: fixed, exp_event: ev});
    endtask

    // offer one poll after a gap and hold it until accepted
    task automatic offer_poll(poll_t p, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        time_now   <= p.now;
        level_key0 <= p.lvl0;
        level_key1 <= p.lvl1;
        fall_key0  <= p.fall0;
        fall_key1  <= p.fall1;
        cur_fixed  <= p.fixed_exp;
        cur_event  <= p.exp_event;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and wait until every event has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write both registers and one unused index
    task automatic load_settings(logic [CfgW-1:0] db, logic [CfgW-1:0] cw);
        cfg_valid <= 1'b1;
        cfg_index <= RegDebounceTime;
        cfg_data  <= db;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= RegChordWindow;
        cfg_data  <= cw;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CfgIndexW'($urandom_range(RegSpareLo, RegSpareHi));
        cfg_data  <= CfgW'($urandom);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stalls, calm stretches and long hold-offs on request
    initial
    begin
        int r;
        int rx_hold;
        int rx_calm;
        int squeeze_seen;
        rx_hold = 0;
        rx_calm = 0;
        squeeze_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_ask != squeeze_seen)
            begin
                squeeze_seen = squeeze_ask;
                rx_hold = 64;
            end
            else if (rx_hold == 0)
            begin
                r = $urandom_range(0, 99);
                if (rx_calm > 0)
                    rx_calm--;
                else if (r < 3)
                    rx_calm = $urandom_range(20, 80);
                else if (r < 25)
                    rx_hold = $urandom_range(1, 3);
                else if (r < 27)
                    rx_hold = $urandom_range(10, 25);
            end
            out_stall <= (rx_hold > 0);
            if (rx_hold > 0)
                rx_hold--;
        end
    end

    // monitor: register writes, accepted polls and returned events
    always @(posedge clk)
    begin
        poll_t p;
        logic [1:0] predicted;
        logic [1:0] awaited;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == RegDebounceTime)
                    trk_debounce = cfg_data;
                else if (cfg_index == RegChordWindow)
                    trk_window = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_events.size() == 0)
                begin
                    $error("key_event %0d returned with no poll outstanding", key_event);
                    mismatch_count++;
                end
                else
                begin
                    awaited = awaited_events.pop_front();
                    if (key_event !== awaited)
                    begin
                        $error("key_event mismatch: expected %0d, actual %0d", awaited, key_event);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                p = '{now: time_now, lvl0: level_key0, lvl1: level_key1, fall0: fall_key0,
                      fall1: fall_key1, fixed_exp: cur_fixed, exp_event: cur_event};
                predicted = predict_key_event(p);
                awaited_events.push_back(cur_fixed ? cur_event : predicted);
            end
        end
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_two_key_debounce_chord_detector_top failed");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [CfgW-1:0] db_set [PhaseCount];
        logic [CfgW-1:0] cw_set [PhaseCount];
        int unsigned span;
        int ph;
        int n;
        int k;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        time_now   <= '0;
        level_key0 <= 1'b1;
        level_key1 <= 1'b1;
        fall_key0  <= 1'b0;
        fall_key1  <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= RegDebounceTime;
        cfg_data   <= '0;
        cur_fixed  <= 1'b0;
        cur_event  <= EvNone;
        mismatch_count = 0;
        squeeze_ask = 0;
        tx_calm = 0;
        key_held[0] = 1'b0;
        key_held[1] = 1'b0;
        trk_debounce = DebounceReset;
        trk_window   = ChordReset;
        for (k = 0; k < 2; k++)
        begin
            trk_phase[k]  = PhIdle;
            trk_pend[k]   = 1'b0;
            trk_edge_t[k] = '0;
            trk_conf_t[k] = '0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed polls at the reset settings (debounce 50, window 150)
        add_poll(32'd0,   1, 1, 0, 0, 1, EvNone);
        add_poll(32'd100, 0, 1, 1, 0, 1, EvNone);   // edge and poll together
        add_poll(32'd120, 0, 1, 0, 0, 0, EvNone);
        add_poll(32'd150, 0, 1, 1, 0, 0, EvNone);   // new edge restarts the timer
        add_poll(32'd200, 0, 1, 0, 0, 0, EvNone);   // debounce exactly elapsed
        add_poll(32'd351, 0, 1, 0, 0, 1, EvKey0);   // window just passed
        add_poll(32'd360, 0, 1, 1, 0, 0, EvNone);   // edge while active
        add_poll(32'd370, 1, 1, 0, 0, 0, EvNone);   // release drops the pending edge
        add_poll(32'd380, 1, 1, 0, 0, 0, EvNone);
        add_poll(32'd400, 0, 0, 1, 1, 0, EvNone);
        add_poll(32'd450, 0, 0, 0, 0, 1, EvBoth);
        add_poll(32'd460, 1, 1, 0, 0, 0, EvNone);
        add_poll(32'hFFFF_FFF0, 1, 0, 0, 1, 0, EvNone);
        add_poll(32'h0000_0030, 1, 0, 0, 0, 0, EvNone);   // debounce across the wrap
        add_poll(32'h0000_00D0, 1, 0, 0, 0, 1, EvKey1);
        add_poll(32'h0000_00D1, 1, 1, 0, 0, 0, EvNone);
        add_poll(32'hFFFF_FF80, 0, 1, 1, 0, 0, EvNone);
        add_poll(32'hFFFF_FFC0, 0, 0, 0, 1, 0, EvNone);
        add_poll(32'h0000_0020, 0, 0, 0, 0, 1, EvBoth);   // chord distance across the wrap
        add_poll(32'h0000_0030, 1, 1, 0, 0, 0, EvNone);
        add_poll(32'h0000_0040, 1, 1, 1, 0, 0, EvNone);   // bounce, released at sampling
        add_poll(32'h0000_0080, 1, 1, 0, 0, 0, EvNone);
        add_poll(32'h0000_0100, 1, 0, 0, 1, 0, EvNone);
        add_poll(32'h0000_00F0, 1, 0, 0, 0, 0, EvNone);   // time going backwards
        add_poll(32'h0000_0010, 1, 0, 0, 0, 1, EvKey1);
        add_poll(32'h0000_0020, 1, 1, 0, 0, 0, EvNone);
        foreach (directed_polls[i])
            offer_poll(directed_polls[i], pick_gap());
        ms_now = 32'h0000_0020;

        // register settings, extremes among them
        db_set[0] = DebounceReset;  cw_set[0] = ChordReset;
        db_set[1] = 16'd0;          cw_set[1] = 16'd0;
        db_set[2] = 16'hFFFF;       cw_set[2] = 16'hFFFF;
        db_set[3] = 16'd0;          cw_set[3] = 16'hFFFF;
        db_set[4] = 16'hFFFF;       cw_set[4] = 16'd0;
        db_set[5] = 16'd10;         cw_set[5] = 16'd30;
        db_set[6] = CfgW'($urandom_range(1, 200));
        cw_set[6] = CfgW'($urandom_range(0, 300));

        // random phases, each opening with a burst against a held-off receiver
        for (ph = 0; ph < PhaseCount; ph++)
        begin
            settle();
            load_settings(db_set[ph], cw_set[ph]);
            span = ((db_set[ph] > cw_set[ph]) ? db_set[ph] : cw_set[ph]) + 4;
            squeeze_ask++;
            for (n = 0; n < PollsPerPhase; n++)
                offer_poll(random_poll(span), (n < BurstPolls) ? 0 : pick_gap());
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_two_key_debounce_chord_detector_top passed");
        else
            $display("tb_two_key_debounce_chord_detector_top failed");
        $finish;
    end

endmodule
